[hw/rtl/gmc_pkg.sv]
// Shared types and constants of the genotype mismatch classifier.
// No dependencies; imported by every module of the block.
package gmc_pkg;

  localparam int ALLELE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int PCT_BITS    = 14;
  localparam int NUM_BITS    = COUNT_BITS + PCT_BITS;
  localparam int STEP_BITS   = 4;
  localparam int IDX_BITS    = 3;

  localparam logic [PCT_BITS-1:0]  PCT_SCALE = PCT_BITS'(10000);
  localparam logic [STEP_BITS-1:0] STEP_TOP  = STEP_BITS'(PCT_BITS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

  // register map (index = paddr / 4)
  localparam logic REG_ALLELE_LOW  = 1'b0;
  localparam logic REG_ALLELE_HIGH = 1'b1;

  localparam logic signed [ALLELE_BITS-1:0] ALLELE_LOW_RESET  = ALLELE_BITS'(0);
  localparam logic signed [ALLELE_BITS-1:0] ALLELE_HIGH_RESET = ALLELE_BITS'(3);

  // which ratio the shared divider is working on
  localparam logic [IDX_BITS-1:0] PCT_MISMATCH   = 3'd0;
  localparam logic [IDX_BITS-1:0] PCT_HOM_HOM    = 3'd1;
  localparam logic [IDX_BITS-1:0] PCT_OVERLAP    = 3'd2;
  localparam logic [IDX_BITS-1:0] PCT_NONOVERLAP = 3'd3;
  localparam logic [IDX_BITS-1:0] PCT_HET_HET    = 3'd4;

  typedef struct packed {
    logic signed [ALLELE_BITS-1:0] first_sample_allele_one;
    logic signed [ALLELE_BITS-1:0] first_sample_allele_two;
    logic signed [ALLELE_BITS-1:0] second_sample_allele_one;
    logic signed [ALLELE_BITS-1:0] second_sample_allele_two;
    logic                          last_locus;
  } gmc_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] valid_loci;
    logic [COUNT_BITS-1:0] mismatched_loci;
    logic [COUNT_BITS-1:0] hom_hom_mismatches;
    logic [COUNT_BITS-1:0] het_hom_overlap_mismatches;
    logic [COUNT_BITS-1:0] het_hom_nonoverlap_mismatches;
    logic [COUNT_BITS-1:0] het_het_mismatches;
    logic [PCT_BITS-1:0]   mismatch_pct;
    logic [PCT_BITS-1:0]   hom_hom_pct;
    logic [PCT_BITS-1:0]   het_hom_overlap_pct;
    logic [PCT_BITS-1:0]   het_hom_nonoverlap_pct;
    logic [PCT_BITS-1:0]   het_het_pct;
    logic                  no_valid_loci;
  } gmc_out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic                 accept;     // take the request into the classify stage
    logic                 load_num;   // load dividend for ratio idx
    logic                 div_step;   // one restoring-division step
    logic                 last_step;  // final step: store quotient
    logic                 load_out;   // fill result register, clear counters
    logic [IDX_BITS-1:0]  idx;
    logic [STEP_BITS-1:0] step;
  } gmc_cmd_t;

endpackage

[hw/rtl/gmc_ctrl.sv]
// Controller of the genotype mismatch classifier: handshakes and the
// end-of-run division sequence. Depends on gmc_pkg.
module gmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gmc_pkg::gmc_cmd_t cmd
);
  import gmc_pkg::*;

  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t               state;
  logic [IDX_BITS-1:0]  idx;
  logic [STEP_BITS-1:0] step;
  logic                 out_free;

  assign in_ready = (state == S_RUN);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.idx       = idx;
    cmd.step      = step;
    cmd.accept    = in_valid && in_ready;
    cmd.load_num  = (state == S_MUL);
    cmd.div_step  = (state == S_DIV);
    cmd.last_step = (state == S_DIV) && (step == '0);
    cmd.load_out  = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      idx       <= PCT_MISMATCH;
      step      <= STEP_TOP;
      out_valid <= 1'b0;
    end else begin
      // in S_FIN a taken result is replaced directly by the new one
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (in_valid && in_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last locus reaches the counters this cycle
          idx   <= PCT_MISMATCH;
          state <= S_MUL;
        end
        S_MUL: begin
          step  <= STEP_TOP;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) begin
            if (idx == PCT_HET_HET) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + IDX_BITS'(1);
              state <= S_MUL;
            end
          end else begin
            step <= step - STEP_BITS'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

endmodule

[hw/rtl/gmc_dp.sv]
// Datapath of the genotype mismatch classifier: locus classify stage,
// saturating counters, serial divider and result register. Depends on gmc_pkg.
module gmc_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  gmc_pkg::gmc_cmd_t                        cmd,
  input  gmc_pkg::gmc_in_t                         in_data,
  input  logic signed [gmc_pkg::ALLELE_BITS-1:0]   allele_low,
  input  logic signed [gmc_pkg::ALLELE_BITS-1:0]   allele_high,
  output gmc_pkg::gmc_out_t                        out_data
);
  import gmc_pkg::*;

  logic signed [ALLELE_BITS-1:0] a0, a1, b0, b1;
  logic in_rng, a_hom, b_hom, mis, ovl;

  // classify stage
  logic st_vld, st_valid, st_mis, st_hh, st_ovl, st_non, st_het;

  logic [COUNT_BITS-1:0] valid_count, mismatch_count, hom_hom_count;
  logic [COUNT_BITS-1:0] overlap_count, nonoverlap_count, het_het_count;
  logic [COUNT_BITS-1:0] sel_count;

  logic [NUM_BITS-1:0] rem, dsh;
  logic [PCT_BITS-1:0] quo, quo_next;
  logic                ge;
  logic [PCT_BITS-1:0] pct_mis, pct_hh, pct_ovl, pct_non, pct_het;
  logic                no_valid;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c, logic en);
    sat_inc = (en && c != CNT_MAX) ? c + COUNT_BITS'(1) : c;
  endfunction

  // sort each genotype pair, smaller allele first
  always_comb begin
    if (in_data.first_sample_allele_one > in_data.first_sample_allele_two) begin
      a0 = in_data.first_sample_allele_two;
      a1 = in_data.first_sample_allele_one;
    end else begin
      a0 = in_data.first_sample_allele_one;
      a1 = in_data.first_sample_allele_two;
    end
    if (in_data.second_sample_allele_one > in_data.second_sample_allele_two) begin
      b0 = in_data.second_sample_allele_two;
      b1 = in_data.second_sample_allele_one;
    end else begin
      b0 = in_data.second_sample_allele_one;
      b1 = in_data.second_sample_allele_two;
    end
    // after sorting, min >= low and max <= high covers all four codes
    in_rng = (a0 >= allele_low) && (a1 <= allele_high) &&
             (b0 >= allele_low) && (b1 <= allele_high);
    a_hom  = (a0 == a1);
    b_hom  = (b0 == b1);
    mis    = !((a0 == b0) && (a1 == b1));
    ovl    = (a_hom && ((a0 == b0) || (a0 == b1))) ||
             (b_hom && ((b0 == a0) || (b0 == a1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= 1'b0;
    end else begin
      st_vld <= cmd.accept;
    end
    st_valid <= in_rng;
    st_mis   <= in_rng && mis;
    st_hh    <= in_rng && mis && a_hom && b_hom;
    st_ovl   <= in_rng && mis && !(a_hom && b_hom) && ovl;
    st_non   <= in_rng && mis && !(a_hom && b_hom) && !ovl && (a_hom || b_hom);
    st_het   <= in_rng && mis && !a_hom && !b_hom;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      valid_count      <= '0;
      mismatch_count   <= '0;
      hom_hom_count    <= '0;
      overlap_count    <= '0;
      nonoverlap_count <= '0;
      het_het_count    <= '0;
    end else if (st_vld) begin
      valid_count      <= sat_inc(valid_count, st_valid);
      mismatch_count   <= sat_inc(mismatch_count, st_mis);
      hom_hom_count    <= sat_inc(hom_hom_count, st_hh);
      overlap_count    <= sat_inc(overlap_count, st_ovl);
      nonoverlap_count <= sat_inc(nonoverlap_count, st_non);
      het_het_count    <= sat_inc(het_het_count, st_het);
    end
  end

  always_comb begin
    case (cmd.idx)
      PCT_MISMATCH:   sel_count = mismatch_count;
      PCT_HOM_HOM:    sel_count = hom_hom_count;
      PCT_OVERLAP:    sel_count = overlap_count;
      PCT_NONOVERLAP: sel_count = nonoverlap_count;
      PCT_HET_HET:    sel_count = het_het_count;
      default:        sel_count = '0;
    endcase
  end

  // restoring division, one quotient bit per cycle, MSB first
  assign dsh      = NUM_BITS'(valid_count) << cmd.step;
  assign ge       = (rem >= dsh);
  assign quo_next = {quo[PCT_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      rem <= NUM_BITS'(sel_count) * NUM_BITS'(PCT_SCALE) +
             NUM_BITS'(valid_count >> 1);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= quo_next;
    end
    if (cmd.last_step) begin
      case (cmd.idx)
        PCT_MISMATCH:   pct_mis <= quo_next;
        PCT_HOM_HOM:    pct_hh  <= quo_next;
        PCT_OVERLAP:    pct_ovl <= quo_next;
        PCT_NONOVERLAP: pct_non <= quo_next;
        PCT_HET_HET:    pct_het <= quo_next;
        default: begin
        end
      endcase
    end
  end

  assign no_valid = (valid_count == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.valid_loci                    <= valid_count;
      out_data.mismatched_loci               <= mismatch_count;
      out_data.hom_hom_mismatches            <= hom_hom_count;
      out_data.het_hom_overlap_mismatches    <= overlap_count;
      out_data.het_hom_nonoverlap_mismatches <= nonoverlap_count;
      out_data.het_het_mismatches            <= het_het_count;
      out_data.mismatch_pct                  <= no_valid ? '0 : pct_mis;
      out_data.hom_hom_pct                   <= no_valid ? '0 : pct_hh;
      out_data.het_hom_overlap_pct           <= no_valid ? '0 : pct_ovl;
      out_data.het_hom_nonoverlap_pct        <= no_valid ? '0 : pct_non;
      out_data.het_het_pct                   <= no_valid ? '0 : pct_het;
      out_data.no_valid_loci                 <= no_valid;
    end
  end

endmodule

[hw/rtl/genotype_mismatch_classifier_unit.sv]
// Genotype mismatch classifier, top level: register port, controller and
// datapath. Depends on gmc_pkg, gmc_ctrl and gmc_dp.
//
// Each request is one locus (two allele codes per sample). Loci are taken one
// per clock while a run is in progress; a locus is counted when all four codes
// lie in [allele_low, allele_high] and, on a mismatch of the sorted genotypes,
// goes into one of four classes (hom-hom, het-hom overlapping, het-hom
// non-overlapping, het-het). All counters saturate at 2^24-1. The request
// marked last_locus closes the run: it is counted, then the five percentages
// (hundredths of a percent, rounded half up) are computed one after another on
// a single shared restoring divider, one quotient bit per clock. Once the
// last locus is accepted, the controller drains it into the counters, then
// per ratio loads the dividend and runs the divide steps, and finally loads
// the result; in_ready stays low meanwhile. The result sits in an output
// register, so the next run can start streaming while the previous result
// waits for out_ready; the end of a later run holds in_ready low longer only
// while that register is still full. With no valid locus all percentages
// read 0 and no_valid_loci is set. Counters clear as the result
// is loaded. allele_low is at address 0x0, allele_high at 0x4 (16-bit signed,
// reset 0 and 3); write them only while the block is idle.
module genotype_mismatch_classifier_unit (
  input  logic               clk,
  input  logic               rst,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // locus requests
  input  logic               in_valid,
  output logic               in_ready,
  input  gmc_pkg::gmc_in_t   in_data,
  // run results
  output logic               out_valid,
  input  logic               out_ready,
  output gmc_pkg::gmc_out_t  out_data
);
  import gmc_pkg::*;

  logic signed [ALLELE_BITS-1:0] allele_low;
  logic signed [ALLELE_BITS-1:0] allele_high;
  logic                          reg_wr;
  gmc_cmd_t                      cmd;

  // register port: no wait states, write on the access phase
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      allele_low  <= ALLELE_LOW_RESET;
      allele_high <= ALLELE_HIGH_RESET;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_ALLELE_LOW:  allele_low  <= pwdata[ALLELE_BITS-1:0];
        REG_ALLELE_HIGH: allele_high <= pwdata[ALLELE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ALLELE_LOW:  prdata = {{(32-ALLELE_BITS){1'b0}}, allele_low};
      REG_ALLELE_HIGH: prdata = {{(32-ALLELE_BITS){1'b0}}, allele_high};
      default:         prdata = '0;
    endcase
  end

  gmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_locus),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gmc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_data     (in_data),
    .allele_low  (allele_low),
    .allele_high (allele_high),
    .out_data    (out_data)
  );

endmodule
